/* rtl/dsfl_pkg.sv */
`default_nettype none
// ============================================================================
// dsfl_pkg: shared types and constants of the descriptor slot free list
// Field widths, request and status codes, register indexes and the
// request record that travels from the front end to the back end.
// ============================================================================
package dsfl_pkg;

    // Field and register widths
    localparam int KIND_W    = 2;
    localparam int IDX_IN_W  = 10;
    localparam int ADDR_W    = 48;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 11;
    localparam int STRIDE_W  = 13;
    localparam int SPAN_W    = COUNT_W + STRIDE_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 48;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 120;

    // Default slot array size
    localparam int DEFAULT_MAX_SLOTS = 1024;

    // Register reset values
    localparam logic [COUNT_W-1:0]  SLOT_COUNT_RESET  = 11'd1024;
    localparam logic [STRIDE_W-1:0] SLOT_STRIDE_RESET = 13'd32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE    = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC    = 2'd0,
        KIND_FREE_IDX = 2'd1,
        KIND_FREE_CPU = 2'd2,
        KIND_FREE_GPU = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_RANGE    = 2'd2,
        ST_ALL_FREE = 2'd3
    } status_t;

    // Classified request: allocate, or free a slot that may be out of range
    typedef struct packed {
        logic               op_alloc;
        logic               oor;
        logic [COUNT_W-1:0] idx;
    } slot_req_t;

    // The slot count register is 11 bits wide, so no more than 2047 slots
    // are ever in use whatever the array size.
    function automatic int eff_slots(input int max_slots);
        return (max_slots < 2047) ? max_slots : 2047;
    endfunction

endpackage : dsfl_pkg
`default_nettype wire

/* rtl/descriptor_slot_free_list.sv */
`default_nettype none
// Flow: the front end classifies each request; a free by address adds a range
//   check and, when in range, a serial divide. The back end pops the freed
//   stack for an allocation when it is not empty, then multiplies and adds.
// The back end takes a new request only after the last result is loaded, and
//   the front end takes no new input while a free by address is in progress.
// Reset: all slots free, registers at reset values; the stack RAM needs no clear.
// ============================================================================
// descriptor_slot_free_list: LIFO slot allocator for a descriptor heap
// Front end classifies requests, a short queue decouples it from the back
// end that owns the free list and forms slot addresses.
// ============================================================================
module descriptor_slot_free_list #(
    parameter int MAX_SLOTS = dsfl_pkg::DEFAULT_MAX_SLOTS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Configuration writes
    input  wire logic                               cfg_we,
    input  wire logic [dsfl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dsfl_pkg::CFG_W-1:0]         cfg_data,
    // Request stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata: slot_index[9:0], address[57:10], zero pad
    input  wire logic [dsfl_pkg::IN_DATA_W-1:0]     s_tdata,
    // s_tuser: kind[1:0]
    input  wire logic [dsfl_pkg::KIND_W-1:0]        s_tuser,
    // Result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata: result_index[9:0], cpu_address[57:10], gpu_address[105:58],
    //          free_slots[116:106], zero pad
    output logic [dsfl_pkg::OUT_DATA_W-1:0]         m_tdata,
    // m_tuser: status[1:0]
    output logic [dsfl_pkg::STATUS_W-1:0]           m_tuser
);

    import dsfl_pkg::*;

    localparam int EFF = eff_slots(MAX_SLOTS);

    logic [COUNT_W-1:0]   slot_count_reg;
    logic [STRIDE_W-1:0]  slot_stride_reg;
    logic [ADDR_W-1:0]    cpu_base_reg;
    logic [ADDR_W-1:0]    gpu_base_reg;
    logic [SPAN_W-1:0]    span_reg;
    logic [COUNT_W-1:0]   count_eff;
    logic                 refill;

    logic                 fq_valid;
    logic                 fq_ready;
    slot_req_t            fq_data;
    logic                 qb_valid;
    logic                 qb_ready;
    slot_req_t            qb_data;

    // Count saturates at the array size
    assign count_eff = (slot_count_reg > COUNT_W'(EFF)) ? COUNT_W'(EFF) : slot_count_reg;
    assign refill    = cfg_we && (cfg_index == REG_SLOT_COUNT);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg  <= SLOT_COUNT_RESET;
            slot_stride_reg <= SLOT_STRIDE_RESET;
            cpu_base_reg    <= '0;
            gpu_base_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SLOT_COUNT:  slot_count_reg  <= cfg_data[COUNT_W-1:0];
                REG_SLOT_STRIDE: slot_stride_reg <= cfg_data[STRIDE_W-1:0];
                REG_CPU_BASE:    cpu_base_reg    <= cfg_data[ADDR_W-1:0];
                REG_GPU_BASE:    gpu_base_reg    <= cfg_data[ADDR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Byte span of the slots in use, for the address range check
    always_ff @(posedge clk)
    begin
        span_reg <= SPAN_W'(count_eff) * SPAN_W'(slot_stride_reg);
    end

    dsfl_front #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .count    (count_eff),
        .stride   (slot_stride_reg),
        .cpu_base (cpu_base_reg),
        .gpu_base (gpu_base_reg),
        .span     (span_reg),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    dsfl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    dsfl_back #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .refill   (refill),
        .count    (count_eff),
        .stride   (slot_stride_reg),
        .cpu_base (cpu_base_reg),
        .gpu_base (gpu_base_reg),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_data   (qb_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule : descriptor_slot_free_list
`default_nettype wire

/* rtl/dsfl_ram.sv */
`default_nettype none
// ============================================================================
// dsfl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module dsfl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : dsfl_ram
`default_nettype wire

/* rtl/dsfl_front.sv */
`default_nettype none
// ============================================================================
// dsfl_front: request intake and classification
// Takes input transfers, turns addresses into slot indexes by a bit-serial
// restoring divide, flags out-of-range requests and hands a record on.
// ============================================================================
module dsfl_front #(
    parameter int MAX_SLOTS = dsfl_pkg::DEFAULT_MAX_SLOTS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // s_tdata: slot_index[9:0], address[57:10], zero pad
    input  wire logic [dsfl_pkg::IN_DATA_W-1:0]      s_tdata,
    // s_tuser: kind[1:0]
    input  wire logic [dsfl_pkg::KIND_W-1:0]         s_tuser,
    input  wire logic [dsfl_pkg::COUNT_W-1:0]        count,
    input  wire logic [dsfl_pkg::STRIDE_W-1:0]       stride,
    input  wire logic [dsfl_pkg::ADDR_W-1:0]         cpu_base,
    input  wire logic [dsfl_pkg::ADDR_W-1:0]         gpu_base,
    input  wire logic [dsfl_pkg::SPAN_W-1:0]         span,
    output logic                                     q_valid,
    input  wire logic                                q_ready,
    output dsfl_pkg::slot_req_t                      q_data
);

    import dsfl_pkg::*;

    localparam int EFF    = eff_slots(MAX_SLOTS);
    localparam int CNT_W  = $clog2(EFF + 1);
    localparam int REM_W  = CNT_W + STRIDE_W;
    localparam int STEP_W = $clog2(CNT_W);

    typedef enum logic [1:0] {
        F_IDLE,
        F_RANGE,
        F_DIV,
        F_SEND
    } fstate_t;

    fstate_t              state_reg;
    slot_req_t            ent_reg;
    logic [ADDR_W-1:0]    diff_reg;
    logic                 borrow_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     div_reg;
    logic [CNT_W-1:0]     quo_reg;
    logic [STEP_W-1:0]    step_reg;

    kind_t                kind;
    logic [IDX_IN_W-1:0]  slot_in;
    logic [ADDR_W-1:0]    addr_in;
    logic [ADDR_W-1:0]    base_sel;
    logic [ADDR_W:0]      diff;
    logic                 idx_oor;
    logic                 addr_oor;
    logic                 fits;
    logic [CNT_W-1:0]     quo_next;

    // Unpack the request
    assign kind    = kind_t'(s_tuser);
    assign slot_in = s_tdata[IDX_IN_W-1:0];
    assign addr_in = s_tdata[IDX_IN_W+ADDR_W-1:IDX_IN_W];

    // Offset from the selected base; top bit is the borrow
    assign base_sel = (kind == KIND_FREE_CPU) ? cpu_base : gpu_base;
    assign diff     = {1'b0, addr_in} - {1'b0, base_sel};
    assign idx_oor  = ({1'b0, slot_in} >= count);

    // Range check of the address offset against count times stride
    assign addr_oor = borrow_reg || (stride == '0) || (diff_reg >= ADDR_W'(span));

    // One quotient bit per cycle
    assign fits     = (rem_reg >= div_reg);
    assign quo_next = {quo_reg[CNT_W-2:0], fits};

    assign s_tready = (state_reg == F_IDLE);
    assign q_valid  = (state_reg == F_SEND);
    assign q_data   = ent_reg;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        case (kind)
                            KIND_ALLOC:
                            begin
                                ent_reg   <= '{op_alloc: 1'b1, oor: 1'b0, idx: '0};
                                state_reg <= F_SEND;
                            end
                            KIND_FREE_IDX:
                            begin
                                ent_reg   <= '{op_alloc: 1'b0, oor: idx_oor,
                                               idx: COUNT_W'(slot_in)};
                                state_reg <= F_SEND;
                            end
                            default:
                            begin
                                diff_reg   <= diff[ADDR_W-1:0];
                                borrow_reg <= diff[ADDR_W];
                                state_reg  <= F_RANGE;
                            end
                        endcase
                    end
                end
                F_RANGE:
                begin
                    if (addr_oor)
                    begin
                        ent_reg   <= '{op_alloc: 1'b0, oor: 1'b1, idx: '0};
                        state_reg <= F_SEND;
                    end
                    else
                    begin
                        // Offset is below count times stride, so it fits REM_W
                        rem_reg   <= diff_reg[REM_W-1:0];
                        div_reg   <= {1'b0, stride, {(CNT_W-1){1'b0}}};
                        quo_reg   <= '0;
                        step_reg  <= STEP_W'(CNT_W - 1);
                        state_reg <= F_DIV;
                    end
                end
                F_DIV:
                begin
                    if (fits)
                    begin
                        rem_reg <= rem_reg - div_reg;
                    end
                    div_reg  <= div_reg >> 1;
                    quo_reg  <= quo_next;
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0)
                    begin
                        ent_reg   <= '{op_alloc: 1'b0, oor: 1'b0, idx: COUNT_W'(quo_next)};
                        state_reg <= F_SEND;
                    end
                end
                F_SEND:
                begin
                    if (q_ready)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule : dsfl_front
`default_nettype wire

/* rtl/dsfl_queue.sv */
`default_nettype none
// ============================================================================
// dsfl_queue: two-entry request queue
// Decouples the front end from the back end so either may stall.
// ============================================================================
module dsfl_queue (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire dsfl_pkg::slot_req_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output dsfl_pkg::slot_req_t out_data
);

    import dsfl_pkg::*;

    slot_req_t   slots_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic        push;
    logic        pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_data  = slots_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= in_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule : dsfl_queue
`default_nettype wire

/* rtl/dsfl_back.sv */
`default_nettype none
// ============================================================================
// dsfl_back: free list execution and result formation
// Holds the freed-slot stack and the fresh counter, applies each request,
// computes the slot addresses and drives the output register.
// ============================================================================
module dsfl_back #(
    parameter int MAX_SLOTS = dsfl_pkg::DEFAULT_MAX_SLOTS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             refill,
    input  wire logic [dsfl_pkg::COUNT_W-1:0]     count,
    input  wire logic [dsfl_pkg::STRIDE_W-1:0]    stride,
    input  wire logic [dsfl_pkg::ADDR_W-1:0]      cpu_base,
    input  wire logic [dsfl_pkg::ADDR_W-1:0]      gpu_base,
    input  wire logic                             q_valid,
    output logic                                  q_ready,
    input  wire dsfl_pkg::slot_req_t              q_data,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata: result_index[9:0], cpu_address[57:10], gpu_address[105:58],
    //          free_slots[116:106], zero pad
    output logic [dsfl_pkg::OUT_DATA_W-1:0]       m_tdata,
    // m_tuser: status[1:0]
    output logic [dsfl_pkg::STATUS_W-1:0]         m_tuser
);

    import dsfl_pkg::*;

    localparam int EFF   = eff_slots(MAX_SLOTS);
    localparam int CNT_W = $clog2(EFF + 1);
    localparam int IDX_W = $clog2(EFF);

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_MUL,
        B_ADD
    } bstate_t;

    bstate_t              state_reg;
    logic [CNT_W-1:0]     depth_reg;
    logic [CNT_W-1:0]     fresh_reg;
    status_t              status_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [SPAN_W-1:0]    off_reg;

    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [IDX_IN_W-1:0]  out_idx_reg;
    logic [ADDR_W-1:0]    out_cpu_reg;
    logic [ADDR_W-1:0]    out_gpu_reg;
    logic [COUNT_W-1:0]   out_free_reg;

    logic [CNT_W-1:0]     cnt;
    logic [CNT_W-1:0]     free_now;
    logic [CNT_W-1:0]     depth_dec;
    logic                 take;
    logic                 push_ok;
    logic                 pop_stack;
    logic [IDX_W-1:0]     stack_rdata;
    logic                 out_free;

    assign cnt       = count[CNT_W-1:0];
    assign free_now  = cnt - fresh_reg + depth_reg;
    assign depth_dec = depth_reg - 1'b1;

    // No transfer from the queue in the cycle the free list restarts
    assign q_ready   = (state_reg == B_IDLE) && !refill;
    assign take      = q_valid && q_ready;
    assign push_ok   = !q_data.op_alloc && !q_data.oor && (free_now < cnt);
    assign pop_stack = q_data.op_alloc && (depth_reg != '0);
    assign out_free  = !out_valid_reg || m_tready;

    // Freed-slot stack
    dsfl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (EFF)
    ) u_stack (
        .clk   (clk),
        .we    (take && push_ok),
        .waddr (depth_reg[IDX_W-1:0]),
        .wdata (q_data.idx[IDX_W-1:0]),
        .re    (take && pop_stack),
        .raddr (depth_dec[IDX_W-1:0]),
        .rdata (stack_rdata)
    );

    // Output ports
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(OUT_DATA_W - IDX_IN_W - 2*ADDR_W - COUNT_W){1'b0}},
                       out_free_reg, out_gpu_reg, out_cpu_reg, out_idx_reg};

    // Sequencer, free list state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            depth_reg      <= '0;
            fresh_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            // Output valid: set when a result is loaded, cleared once taken
            if ((state_reg == B_ADD) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                B_IDLE:
                begin
                    if (take)
                    begin
                        if (pop_stack)
                        begin
                            depth_reg <= depth_dec;
                            state_reg <= B_READ;
                        end
                        else
                        begin
                            state_reg <= B_MUL;
                            if (q_data.op_alloc)
                            begin
                                if (fresh_reg < cnt)
                                begin
                                    idx_reg    <= fresh_reg[IDX_W-1:0];
                                    fresh_reg  <= fresh_reg + 1'b1;
                                    status_reg <= ST_OK;
                                end
                                else
                                begin
                                    idx_reg    <= '0;
                                    status_reg <= ST_NO_FREE;
                                end
                            end
                            else if (q_data.oor)
                            begin
                                idx_reg    <= '0;
                                status_reg <= ST_RANGE;
                            end
                            else if (!push_ok)
                            begin
                                idx_reg    <= '0;
                                status_reg <= ST_ALL_FREE;
                            end
                            else
                            begin
                                idx_reg    <= q_data.idx[IDX_W-1:0];
                                depth_reg  <= depth_reg + 1'b1;
                                status_reg <= ST_OK;
                            end
                        end
                    end
                end
                B_READ:
                begin
                    idx_reg    <= stack_rdata;
                    status_reg <= ST_OK;
                    state_reg  <= B_MUL;
                end
                B_MUL:
                begin
                    off_reg   <= SPAN_W'(idx_reg) * SPAN_W'(stride);
                    state_reg <= B_ADD;
                end
                B_ADD:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= status_reg;
                        out_idx_reg    <= IDX_IN_W'(idx_reg);
                        out_free_reg   <= COUNT_W'(free_now);
                        if (status_reg == ST_OK)
                        begin
                            out_cpu_reg <= cpu_base + ADDR_W'(off_reg);
                            out_gpu_reg <= gpu_base + ADDR_W'(off_reg);
                        end
                        else
                        begin
                            out_cpu_reg <= '0;
                            out_gpu_reg <= '0;
                        end
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase

            // Slot count write restarts the free list
            if (refill)
            begin
                depth_reg <= '0;
                fresh_reg <= '0;
            end
        end
    end

endmodule : dsfl_back
`default_nettype wire
